// ===== hw/rtl/cteq_pkg.sv =====
`default_nettype none
package cteq_pkg;

    typedef enum logic [1:0] {
        OP_WR_RANGE = 2'd0,
        OP_WR_SEG   = 2'd1,
        OP_WR_DST   = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  entity;
        logic [11:0] position;
        logic [7:0]  relation;
        logic [12:0] range_low;
        logic [12:0] range_high;
        logic [9:0]  target;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [12:0] degree;
        logic [12:0] unique_relations;
    } out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/csr_triple_edge_query_top.sv =====
// Edge lookup in a labelled graph held in three tables.
// Channel in (in_valid/in_ready, in_data) carries one word per item: writes
// of the entity range, relation segment and destination tables, or a query.
// Channel out (out_valid/out_ready, out_data) returns one word per query
// (found, degree, unique_relations); writes return nothing.
// One item is handled at a time. A query searches the segments and, on a
// relation match, the destinations: at most 13 probes in each search for the
// default table sizes. Every probe is one read of the synchronous segment
// or destination memory, which has one write port and one read port.
// After reset the entity range table is swept clear, one entry a cycle;
// in_ready is low during the sweep.
// The result sits in an output register; while out_ready is low a new
// write may still be accepted, but a new query waits until the result
// has been taken.
`default_nettype none
module csr_triple_edge_query_top #(
    parameter int NUM_ENTITIES = 1024,
    parameter int MAX_SEGMENTS = 4096,
    parameter int MAX_EDGES    = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cteq_pkg::in_word_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cteq_pkg::out_word_t       out_data
);
    localparam int EW = $clog2(NUM_ENTITIES) > 0 ? $clog2(NUM_ENTITIES) : 1;
    localparam int SW = $clog2(MAX_SEGMENTS) > 0 ? $clog2(MAX_SEGMENTS) : 1;
    localparam int DW = $clog2(MAX_EDGES) > 0 ? $clog2(MAX_EDGES) : 1;
    localparam logic [13:0] SEG_LIM = 14'(MAX_SEGMENTS);
    localparam logic [13:0] DST_LIM = 14'(MAX_EDGES);
    localparam logic [20:0] ENT_LIM = 21'(NUM_ENTITIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RANGE, S_FIRST, S_LAST, S_SPROBE, S_SCHECK,
        S_DSETUP, S_DPROBE, S_DCHECK, S_DFINAL, S_DONE
    } state_t;

    state_t state_reg;
    logic [EW-1:0] clr_reg;
    cteq_pkg::in_word_t q_reg;
    logic [13:0] lo_reg, hi_reg, l_reg, r_reg, first_reg, cnt_reg, step_reg;
    logic [12:0] dlo0_reg, uniq_reg;
    logic found_reg;

    // Entity range memory.
    logic          er_we;
    logic [EW-1:0] er_waddr, er_raddr;
    logic [25:0]   er_wdata, er_rdata;
    // Segment memory.
    logic          sg_we;
    logic [SW-1:0] sg_waddr, sg_raddr;
    logic [33:0]   sg_wdata, sg_rdata;
    // Destination memory.
    logic          ds_we;
    logic [DW-1:0] ds_waddr, ds_raddr;
    logic [9:0]    ds_wdata, ds_rdata;

    cteq_ram #(.WIDTH(26), .DEPTH(NUM_ENTITIES)) u_er (.clk(clk), .we(er_we),
        .waddr(er_waddr), .wdata(er_wdata), .raddr(er_raddr), .rdata(er_rdata));
    cteq_ram #(.WIDTH(34), .DEPTH(MAX_SEGMENTS)) u_sg (.clk(clk), .we(sg_we),
        .waddr(sg_waddr), .wdata(sg_wdata), .raddr(sg_raddr), .rdata(sg_rdata));
    cteq_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_ds (.clk(clk), .we(ds_we),
        .waddr(ds_waddr), .wdata(ds_wdata), .raddr(ds_raddr), .rdata(ds_rdata));

    logic accept;
    logic is_query;
    logic [13:0] mid, hi_c, dhi_c, it, last_seg;
    logic [7:0] cur_rel;
    logic [12:0] s_lo, s_hi;

    assign is_query = in_data.operation == cteq_pkg::OP_QUERY;
    assign in_ready = (state_reg == S_IDLE) && !(is_query && out_valid);
    assign accept   = in_valid && in_ready;

    assign cur_rel  = sg_rdata[7:0];
    assign s_lo     = sg_rdata[20:8];
    assign s_hi     = sg_rdata[33:21];
    assign mid      = 14'((15'(l_reg) + 15'(r_reg)) >> 1);
    assign hi_c     = ({1'b0, er_rdata[25:13]} > SEG_LIM) ? SEG_LIM : {1'b0, er_rdata[25:13]};
    assign dhi_c    = ({1'b0, s_hi} > DST_LIM) ? DST_LIM : {1'b0, s_hi};
    assign it       = first_reg + (cnt_reg >> 1);
    assign last_seg = hi_reg - 14'd1;

    always_comb
    begin
        er_we    = 1'b0;
        er_waddr = in_data.entity[EW-1:0];
        er_wdata = {in_data.range_high, in_data.range_low};
        er_raddr = in_data.entity[EW-1:0];
        sg_we    = 1'b0;
        sg_waddr = in_data.position[SW-1:0];
        sg_wdata = {in_data.range_high, in_data.range_low, in_data.relation};
        sg_raddr = lo_reg[SW-1:0];
        ds_we    = 1'b0;
        ds_waddr = in_data.position[DW-1:0];
        ds_wdata = in_data.target;
        ds_raddr = it[DW-1:0];
        if (state_reg == S_CLEAR)
        begin
            er_we    = 1'b1;
            er_waddr = clr_reg;
            er_wdata = '0;
        end
        else if (accept)
        begin
            unique case (cteq_pkg::op_t'(in_data.operation))
                cteq_pkg::OP_WR_RANGE:
                    er_we = 21'(in_data.entity) < ENT_LIM;
                cteq_pkg::OP_WR_SEG:
                    sg_we = 21'(in_data.position) < 21'(SEG_LIM);
                cteq_pkg::OP_WR_DST:
                    ds_we = 21'(in_data.position) < 21'(DST_LIM);
                cteq_pkg::OP_QUERY: ;
            endcase
        end
        unique case (state_reg)
            S_LAST:   sg_raddr = last_seg[SW-1:0];
            S_SPROBE: sg_raddr = mid[SW-1:0];
            default:  sg_raddr = lo_reg[SW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + EW'(1);
                    if (21'(clr_reg) == ENT_LIM - 21'd1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept && is_query)
                    begin
                        q_reg     <= in_data;
                        state_reg <= S_RANGE;
                    end
                end
                S_RANGE:
                begin
                    // Range word is on the read port now.
                    lo_reg <= {1'b0, er_rdata[12:0]};
                    hi_reg <= hi_c;
                    found_reg <= 1'b0;
                    if (21'(q_reg.entity) >= ENT_LIM || {1'b0, er_rdata[12:0]} >= hi_c)
                    begin
                        uniq_reg  <= '0;
                        out_data  <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        uniq_reg  <= 13'(hi_c - {1'b0, er_rdata[12:0]});
                        state_reg <= S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    // The read of the first segment is issued in this cycle.
                    state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    dlo0_reg  <= s_lo;
                    l_reg     <= lo_reg;
                    r_reg     <= hi_reg - 14'd1;
                    state_reg <= S_SPROBE;
                end
                S_SPROBE:
                begin
                    if (step_reg == 14'd0)
                    begin
                        out_data.degree <= 13'(s_hi - dlo0_reg);
                        step_reg <= 14'd1;
                    end
                    state_reg <= S_SCHECK;
                end
                S_SCHECK:
                begin
                    if (cur_rel == q_reg.relation)
                    begin
                        first_reg <= {1'b0, s_lo};
                        lo_reg    <= {1'b0, s_lo};
                        hi_reg    <= dhi_c;
                        cnt_reg   <= dhi_c - {1'b0, s_lo};
                        state_reg <= ({1'b0, s_lo} < dhi_c) ? S_DPROBE : S_DFINAL;
                    end
                    else if (q_reg.relation < cur_rel && mid != l_reg)
                    begin
                        r_reg     <= mid - 14'd1;
                        state_reg <= (l_reg <= mid - 14'd1) ? S_SPROBE : S_DFINAL;
                    end
                    else if (q_reg.relation > cur_rel)
                    begin
                        l_reg     <= mid + 14'd1;
                        state_reg <= (mid + 14'd1 <= r_reg) ? S_SPROBE : S_DFINAL;
                    end
                    else
                    begin
                        state_reg <= S_DFINAL;
                    end
                end
                S_DPROBE:
                begin
                    if (cnt_reg == 14'd0)
                    begin
                        state_reg <= S_DCHECK;
                    end
                    else
                    begin
                        state_reg <= S_DSETUP;
                    end
                end
                S_DSETUP:
                begin
                    // Destination at it is on the read port.
                    if (ds_rdata < q_reg.target)
                    begin
                        first_reg <= it + 14'd1;
                        cnt_reg   <= cnt_reg - (cnt_reg >> 1) - 14'd1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg >> 1;
                    end
                    state_reg <= S_DPROBE;
                end
                S_DCHECK:
                begin
                    // cnt is zero, so the read address was first.
                    state_reg <= S_DONE;
                    found_reg <= (first_reg != hi_reg) && (ds_rdata == q_reg.target);
                end
                S_DFINAL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    out_data.found            <= found_reg;
                    out_data.unique_relations <= uniq_reg;
                    if (uniq_reg == 13'd0)
                    begin
                        out_data.degree <= '0;
                    end
                    out_valid <= 1'b1;
                    step_reg  <= 14'd0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_IDLE && accept && is_query)
            begin
                step_reg <= 14'd0;
            end
        end
    end

    // The degree is captured from the first probe cycle, where the last
    // segment word (read in S_LAST) is still on the read port.
endmodule
`default_nettype wire

// ===== hw/rtl/cteq_ram.sv =====
`default_nettype none
module cteq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
